// File: rtl/isots_pkg.sv
// ----------------------------------------------------------------------------
// isots_pkg: shared types and constants for the timestamp converter
// Holds the parser position codes, the character codes, the record that the
// parser hands to the converter, the converter state type and calendar tables.
// ----------------------------------------------------------------------------
package isots_pkg;

  // Widths of the result and of the working accumulator, and the queue depth.
  localparam int EPOCH_W     = 49;
  localparam int TDATA_OUT_W = 56;
  localparam int QUEUE_DEPTH = 2;

  // Parser positions within the text.
  localparam logic [4:0] PH_YEAR0     = 5'd0;
  localparam logic [4:0] PH_YEAR3     = 5'd3;
  localparam logic [4:0] PH_DASH1     = 5'd4;
  localparam logic [4:0] PH_MON0      = 5'd5;
  localparam logic [4:0] PH_MON1      = 5'd6;
  localparam logic [4:0] PH_DASH2     = 5'd7;
  localparam logic [4:0] PH_DAY0      = 5'd8;
  localparam logic [4:0] PH_DAY1      = 5'd9;
  localparam logic [4:0] PH_SEP_T     = 5'd10;
  localparam logic [4:0] PH_HOUR0     = 5'd11;
  localparam logic [4:0] PH_HOUR1     = 5'd12;
  localparam logic [4:0] PH_COLON1    = 5'd13;
  localparam logic [4:0] PH_MIN0      = 5'd14;
  localparam logic [4:0] PH_MIN1      = 5'd15;
  localparam logic [4:0] PH_COLON2    = 5'd16;
  localparam logic [4:0] PH_SEC0      = 5'd17;
  localparam logic [4:0] PH_SEC1      = 5'd18;
  localparam logic [4:0] PH_TAIL      = 5'd19;
  localparam logic [4:0] PH_FRAC1     = 5'd20;
  localparam logic [4:0] PH_FRACN     = 5'd21;
  localparam logic [4:0] PH_DONE_Z    = 5'd22;
  localparam logic [4:0] PH_OFF_H0    = 5'd23;
  localparam logic [4:0] PH_OFF_H1    = 5'd24;
  localparam logic [4:0] PH_OFF_COLON = 5'd25;
  localparam logic [4:0] PH_OFF_M0    = 5'd26;
  localparam logic [4:0] PH_OFF_M1    = 5'd27;
  localparam logic [4:0] PH_DONE_OFF  = 5'd28;

  // ASCII codes that the parser looks for.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // One parsed timestamp, as handed from the parser to the converter.
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  millis;
    logic [1:0]  frac_cnt;
    logic        off_neg;
    logic [6:0]  off_hour;
    logic [6:0]  off_minute;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_MSEC,
    ST_OFFS
  } back_state_t;

  // Days before the first of a month, counted from the first of March.
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] res;
    begin
      case (month)
        4'd3:    res = 9'd0;
        4'd4:    res = 9'd31;
        4'd5:    res = 9'd61;
        4'd6:    res = 9'd92;
        4'd7:    res = 9'd122;
        4'd8:    res = 9'd153;
        4'd9:    res = 9'd184;
        4'd10:   res = 9'd214;
        4'd11:   res = 9'd245;
        4'd12:   res = 9'd275;
        4'd1:    res = 9'd306;
        4'd2:    res = 9'd337;
        default: res = 9'd0;
      endcase
      return res;
    end
  endfunction

  // Length of a month; zero for a month number that does not exist.
  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] res;
    begin
      case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: res = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    res = 5'd30;
        4'd2:    res = leap ? 5'd29 : 5'd28;
        default: res = 5'd0;
      endcase
      return res;
    end
  endfunction

endpackage

// File: rtl/isots_front.sv
// ----------------------------------------------------------------------------
// isots_front: character parser
// Checks each character against its position, collects the date, time,
// fraction and offset digits, and pushes one record on the final character.
// ----------------------------------------------------------------------------
module isots_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output isots_pkg::rec_t     q_rec
);

  logic [4:0]      phase_r, phase_nxt;
  logic            err_r, err_nxt;
  isots_pkg::rec_t acc_r, acc_nxt;
  logic            accept;
  logic            dig;
  logic [3:0]      dval;
  logic            ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign dig      = (in_char >= isots_pkg::CH_ZERO) && (in_char <= isots_pkg::CH_NINE);
  assign dval     = in_char[3:0];

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    ok        = 1'b1;
    if (!err_r) begin
      case (phase_r) inside
        [isots_pkg::PH_YEAR0:isots_pkg::PH_YEAR3]: begin
          ok = dig;
          acc_nxt.year = acc_r.year * 14'd10 + {10'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_MON0, isots_pkg::PH_MON1: begin
          ok = dig;
          acc_nxt.month = acc_r.month * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_DAY0, isots_pkg::PH_DAY1: begin
          ok = dig;
          acc_nxt.day = acc_r.day * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_HOUR0, isots_pkg::PH_HOUR1: begin
          ok = dig;
          acc_nxt.hour = acc_r.hour * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_MIN0, isots_pkg::PH_MIN1: begin
          ok = dig;
          acc_nxt.minute = acc_r.minute * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_SEC0, isots_pkg::PH_SEC1: begin
          ok = dig;
          acc_nxt.second = acc_r.second * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_OFF_H0, isots_pkg::PH_OFF_H1: begin
          ok = dig;
          acc_nxt.off_hour = acc_r.off_hour * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_OFF_M0, isots_pkg::PH_OFF_M1: begin
          ok = dig;
          acc_nxt.off_minute = acc_r.off_minute * 7'd10 + {3'd0, dval};
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_DASH1, isots_pkg::PH_DASH2: begin
          ok = (in_char == isots_pkg::CH_DASH);
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_SEP_T: begin
          ok = (in_char == isots_pkg::CH_T);
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_COLON1, isots_pkg::PH_COLON2, isots_pkg::PH_OFF_COLON: begin
          ok = (in_char == isots_pkg::CH_COLON);
          phase_nxt = phase_r + 5'd1;
        end
        isots_pkg::PH_TAIL, isots_pkg::PH_FRACN: begin
          if ((phase_r == isots_pkg::PH_TAIL) && (in_char == isots_pkg::CH_DOT)) begin
            phase_nxt = isots_pkg::PH_FRAC1;
          end else if ((phase_r == isots_pkg::PH_FRACN) && dig) begin
            // Digits past the third are accepted and dropped.
            if (acc_r.frac_cnt != 2'd3) begin
              acc_nxt.millis   = acc_r.millis * 10'd10 + {6'd0, dval};
              acc_nxt.frac_cnt = acc_r.frac_cnt + 2'd1;
            end
          end else if (in_char == isots_pkg::CH_Z) begin
            phase_nxt = isots_pkg::PH_DONE_Z;
          end else if ((in_char == isots_pkg::CH_PLUS) || (in_char == isots_pkg::CH_DASH)) begin
            acc_nxt.off_neg = (in_char == isots_pkg::CH_DASH);
            phase_nxt = isots_pkg::PH_OFF_H0;
          end else begin
            ok = 1'b0;
          end
        end
        isots_pkg::PH_FRAC1: begin
          ok = dig;
          acc_nxt.millis   = {6'd0, dval};
          acc_nxt.frac_cnt = 2'd1;
          phase_nxt = isots_pkg::PH_FRACN;
        end
        default: begin
          // Anything after the zone designator, or an unused position.
          ok = 1'b0;
        end
      endcase
    end
    err_nxt = err_r || !ok;
    acc_nxt.ok = !err_nxt &&
                 ((phase_nxt == isots_pkg::PH_DONE_Z) || (phase_nxt == isots_pkg::PH_DONE_OFF));
  end

  assign q_push = accept && in_last;
  assign q_rec  = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= isots_pkg::PH_YEAR0;
      err_r   <= 1'b0;
      acc_r   <= '0;
    end else if (accept) begin
      if (in_last) begin
        phase_r <= isots_pkg::PH_YEAR0;
        err_r   <= 1'b0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

endmodule

// File: rtl/isots_queue.sv
// ----------------------------------------------------------------------------
// isots_queue: record queue between parser and converter
// A small first-in first-out buffer of parsed records.
// ----------------------------------------------------------------------------
module isots_queue #(
  parameter int DEPTH = isots_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  isots_pkg::rec_t push_rec,
  input  logic            pop,
  output isots_pkg::rec_t pop_rec,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  isots_pkg::rec_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_rec  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/isots_back.sv
// ----------------------------------------------------------------------------
// isots_back: calendar converter
// Range-checks one record and turns it into epoch milliseconds with a
// short sequence of multiply-add steps, then holds it in the output register.
// ----------------------------------------------------------------------------
module isots_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  isots_pkg::rec_t                      q_rec,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_flag,
  output logic signed [isots_pkg::EPOCH_W-1:0] out_epoch
);

  localparam int AW = isots_pkg::EPOCH_W;

  isots_pkg::back_state_t state_r, state_nxt;
  isots_pkg::rec_t        rec_r, rec_nxt;
  logic [13:0]            y_r, y_nxt;
  logic [7:0]             qy_r, qy_nxt;
  logic [7:0]             qyr_r, qyr_nxt;
  logic signed [24:0]     days_r, days_nxt;
  logic                   vld_r, vld_nxt;
  logic [9:0]             frac_r, frac_nxt;
  logic [12:0]            offm_r, offm_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic                   oflag_r, oflag_nxt;
  logic signed [AW-1:0]   oepoch_r, oepoch_nxt;

  logic [26:0]            prod_y, prod_yr;
  logic [13:0]            rem100;
  logic                   leap;
  logic [4:0]             dim;
  logic [22:0]            pos;
  logic [28:0]            offp;
  logic signed [AW-1:0]   offs;
  logic                   range_ok;

  assign q_pop     = (state_r == isots_pkg::ST_IDLE) && !q_empty;
  assign out_valid = ovalid_r;
  assign out_flag  = oflag_r;
  assign out_epoch = oepoch_r;

  always_comb begin
    state_nxt  = state_r;
    rec_nxt    = rec_r;
    y_nxt      = y_r;
    qy_nxt     = qy_r;
    qyr_nxt    = qyr_r;
    days_nxt   = days_r;
    vld_nxt    = vld_r;
    frac_nxt   = frac_r;
    offm_nxt   = offm_r;
    acc_nxt    = acc_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oflag_nxt  = oflag_r;
    oepoch_nxt = oepoch_r;

    // Floor division by 100 through a reciprocal: exact below 16384.
    prod_y  = {13'd0, y_r} * 27'd5243;
    prod_yr = {13'd0, rec_r.year} * 27'd5243;

    rem100   = rec_r.year - 14'({6'd0, qyr_r} * 14'd100);
    leap     = (rem100 == 14'd0) ? (qyr_r[1:0] == 2'd0) : (rec_r.year[1:0] == 2'd0);
    dim      = isots_pkg::days_in_month(rec_r.month[3:0], leap);
    range_ok = (rec_r.month >= 7'd1) && (rec_r.month <= 7'd12) &&
               (rec_r.day >= 7'd1) && (rec_r.day <= {2'd0, dim}) &&
               (rec_r.hour <= 7'd23) && (rec_r.minute <= 7'd59) &&
               (rec_r.second <= 7'd59) && (rec_r.off_hour <= 7'd23) &&
               (rec_r.off_minute <= 7'd59);
    // Shifted year Y = year - (Jan/Feb) + 400 keeps the sums non-negative.
    pos = 23'(y_r) * 23'd365 + 23'(y_r[13:2]) - 23'(qy_r) + 23'(qy_r[7:2]) +
          23'(isots_pkg::month_offset(rec_r.month[3:0])) + 23'(rec_r.day);

    offp = 29'(offm_r) * 29'd60000;
    offs = $signed({20'd0, offp});

    case (state_r)
      isots_pkg::ST_IDLE: begin
        if (!q_empty) begin
          rec_nxt   = q_rec;
          y_nxt     = q_rec.year + 14'd400 -
                      {13'd0, (q_rec.month <= 7'd2)};
          state_nxt = isots_pkg::ST_DIV;
        end
      end
      isots_pkg::ST_DIV: begin
        qy_nxt    = prod_y[26:19];
        qyr_nxt   = prod_yr[26:19];
        state_nxt = isots_pkg::ST_DAYS;
      end
      isots_pkg::ST_DAYS: begin
        vld_nxt  = rec_r.ok && range_ok;
        // 865566 = 146097 (era shift) + 719468 (epoch) + 1 (day is 1-based).
        days_nxt = $signed({2'd0, pos}) - 25'sd865566;
        case (rec_r.frac_cnt)
          2'd1:    frac_nxt = rec_r.millis * 10'd100;
          2'd2:    frac_nxt = rec_r.millis * 10'd10;
          default: frac_nxt = rec_r.millis;
        endcase
        offm_nxt  = 13'(rec_r.off_hour) * 13'd60 + 13'(rec_r.off_minute);
        state_nxt = isots_pkg::ST_HOUR;
      end
      isots_pkg::ST_HOUR: begin
        acc_nxt   = AW'(days_r) * 49'sd24 + $signed({42'd0, rec_r.hour});
        state_nxt = isots_pkg::ST_MIN;
      end
      isots_pkg::ST_MIN: begin
        acc_nxt   = acc_r * 49'sd60 + $signed({42'd0, rec_r.minute});
        state_nxt = isots_pkg::ST_SEC;
      end
      isots_pkg::ST_SEC: begin
        acc_nxt   = acc_r * 49'sd60 + $signed({42'd0, rec_r.second});
        state_nxt = isots_pkg::ST_MSEC;
      end
      isots_pkg::ST_MSEC: begin
        acc_nxt   = acc_r * 49'sd1000 + $signed({39'd0, frac_r});
        state_nxt = isots_pkg::ST_OFFS;
      end
      isots_pkg::ST_OFFS: begin
        // Wait here while the previous word is still unclaimed.
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          oflag_nxt  = vld_r;
          if (vld_r) begin
            oepoch_nxt = rec_r.off_neg ? acc_r + offs : acc_r - offs;
          end else begin
            oepoch_nxt = '0;
          end
          state_nxt = isots_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isots_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= isots_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r    <= rec_nxt;
    y_r      <= y_nxt;
    qy_r     <= qy_nxt;
    qyr_r    <= qyr_nxt;
    days_r   <= days_nxt;
    vld_r    <= vld_nxt;
    frac_r   <= frac_nxt;
    offm_r   <= offm_nxt;
    acc_r    <= acc_nxt;
    oflag_r  <= oflag_nxt;
    oepoch_r <= oepoch_nxt;
  end

endmodule

// File: rtl/iso_timestamp_to_epoch_ms.sv
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch_ms: ISO-8601 timestamp text to epoch milliseconds
// Streams a timestamp in one character per word and returns one word per
// string with a validity flag and the signed milliseconds since 1970.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle while the queue is not full; the
// converter takes a new record only after it has loaded the last result. The
// result word is set by the seven-step multiply-add sequence of the converter.
// The queue holds two parsed strings, and input stalls while it is full.
// Reset (rst_n low, synchronous) returns the parser to the start of a string,
// empties the queue and drops any result word not yet taken.
// ----------------------------------------------------------------------------
module iso_timestamp_to_epoch_ms #(
  parameter int QUEUE_DEPTH = isots_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel: one character per word.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] char_code
  input  logic                                  in_tlast,  // last_char
  // Result channel: one word per string.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [isots_pkg::TDATA_OUT_W-1:0]     out_tdata, // [48:0] epoch_ms, rest zero
  output logic                                  out_tuser  // [0] valid_res
);

  // The design is split into a front part that parses characters at full rate
  // while the queue has room and a back part that does the calendar arithmetic.
  // They meet at a small record queue, which holds up the front only when full.

  logic                                  q_push;
  logic                                  q_pop;
  logic                                  q_full;
  logic                                  q_empty;
  isots_pkg::rec_t                       push_rec;
  isots_pkg::rec_t                       pop_rec;
  logic signed [isots_pkg::EPOCH_W-1:0]  epoch;

  // Front: checks every character against its position and gathers the
  // numeric fields. On the last character the finished record is pushed.
  isots_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  isots_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: days-from-civil and the time-of-day products, computed in a sequence of
  // steps, ending in the output register that drives the result channel.
  isots_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_flag  (out_tuser),
    .out_epoch (epoch)
  );

  // The epoch value is padded with zeros up to a whole number of bytes.
  assign out_tdata = {{(isots_pkg::TDATA_OUT_W - isots_pkg::EPOCH_W){1'b0}}, epoch};

endmodule

// File: rtl/isots_checker.sv
// ----------------------------------------------------------------------------
// isots_checker: port-level checks for the timestamp converter
// Watches the top-level channels and flags behavior the design never shows.
// ----------------------------------------------------------------------------
module isots_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [isots_pkg::TDATA_OUT_W-1:0] out_tdata,
  input logic                              out_tuser
);

  // A stalled result word holds still.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A rejected string reports zero milliseconds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid result carries a nonzero value");

  // A valid result lies within the representable calendar range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ($signed(out_tdata[48:0]) >= -49'sd62167305540000) &&
      ($signed(out_tdata[48:0]) <= 49'sd253402387139999) &&
      (out_tdata[55:49] == 7'd0))
    else $error("valid result out of range");

  // Once out of reset, both handshake outputs always carry a defined level.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_tready) && !$isunknown(out_tvalid))
    else $error("handshake output undefined");

endmodule

bind iso_timestamp_to_epoch_ms isots_checker u_isots_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for iso_timestamp_to_epoch_ms
// Streams ISO-8601 timestamp text into the converter one character per word.
// A predictor in the bench parses the same characters and works out the
// validity flag and epoch milliseconds of every string. Each result word is
// checked against the oldest pending prediction, under random stalls on both
// channels.
// ----------------------------------------------------------------------------
module testbench;

  // No word may be stuck longer than this many cycles. The slowest legal case
  // is a run of long receiver stalls behind a full queue.
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_CHARS = 1320;
  localparam int MAX_REPORTS = 40;

  // One predicted result word.
  typedef struct {
    bit         ok;
    logic [isots_pkg::EPOCH_W-1:0] ms;
  } stamp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [isots_pkg::TDATA_OUT_W-1:0] out_tdata;
  logic out_tuser;

  always #4 clk = ~clk;

  iso_timestamp_to_epoch_ms DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a parser that mirrors the character-by-character rules.
  // --------------------------------------------------------------------------
  logic [4:0]  pos;
  logic [13:0] year_v;
  logic [6:0]  mon_v;
  logic [6:0]  day_v;
  logic [6:0]  hour_v;
  logic [6:0]  min_v;
  logic [6:0]  sec_v;
  logic [9:0]  millis_v;
  logic [1:0]  frac_digits;
  logic        off_neg;
  logic [6:0]  off_hour_v;
  logic [6:0]  off_min_v;
  logic        bad_char;

  // Results predicted but not yet seen on the result channel, oldest first.
  stamp_t pending_stamps[$];

  int error_count = 0;
  int chars_sent = 0;
  int calm_left = 0;
  int quiet_cycles = 0;

  // Characters of the string being built for the next send.
  byte unsigned text_buf[$];

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  function void clear_parser();
    pos = isots_pkg::PH_YEAR0;
    year_v = '0;
    mon_v = '0;
    day_v = '0;
    hour_v = '0;
    min_v = '0;
    sec_v = '0;
    millis_v = '0;
    frac_digits = '0;
    off_neg = 1'b0;
    off_hour_v = '0;
    off_min_v = '0;
    bad_char = 1'b0;
  endfunction

  // Only the first three fraction digits count; later ones are dropped.
  function void add_fraction_digit(input logic [3:0] d);
    if (frac_digits < 2'd3) begin
      millis_v = 10'(millis_v * 10 + d);
      frac_digits = frac_digits + 2'd1;
    end
  endfunction

  function bit take_offset_sign(input logic [7:0] c);
    if (c == isots_pkg::CH_PLUS || c == isots_pkg::CH_DASH) begin
      off_neg = (c == isots_pkg::CH_DASH);
      pos = isots_pkg::PH_OFF_H0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the parser by one character. A character that does not fit its
  // position latches the error flag, after which the string is dead.
  function void take_char(input logic [7:0] c);
    bit         dig;
    logic [3:0] d;
    bit         ok;
    bit         bump;
    dig = (c >= isots_pkg::CH_ZERO) && (c <= isots_pkg::CH_NINE);
    d = dig ? 4'(c - isots_pkg::CH_ZERO) : 4'd0;
    ok = 1'b1;
    bump = 1'b1;
    case (pos)
      isots_pkg::PH_DASH1, isots_pkg::PH_DASH2: ok = (c == isots_pkg::CH_DASH);
      isots_pkg::PH_MON0, isots_pkg::PH_MON1: begin
        if (dig) mon_v = 7'(mon_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_DAY0, isots_pkg::PH_DAY1: begin
        if (dig) day_v = 7'(day_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_SEP_T: ok = (c == isots_pkg::CH_T);
      isots_pkg::PH_HOUR0, isots_pkg::PH_HOUR1: begin
        if (dig) hour_v = 7'(hour_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_COLON1, isots_pkg::PH_COLON2, isots_pkg::PH_OFF_COLON:
        ok = (c == isots_pkg::CH_COLON);
      isots_pkg::PH_MIN0, isots_pkg::PH_MIN1: begin
        if (dig) min_v = 7'(min_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_SEC0, isots_pkg::PH_SEC1: begin
        if (dig) sec_v = 7'(sec_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_OFF_H0, isots_pkg::PH_OFF_H1: begin
        if (dig) off_hour_v = 7'(off_hour_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_OFF_M0, isots_pkg::PH_OFF_M1: begin
        if (dig) off_min_v = 7'(off_min_v * 10 + d); else ok = 1'b0;
      end
      isots_pkg::PH_TAIL: begin
        bump = 1'b0;
        if (c == isots_pkg::CH_DOT) pos = isots_pkg::PH_FRAC1;
        else if (c == isots_pkg::CH_Z) pos = isots_pkg::PH_DONE_Z;
        else ok = take_offset_sign(c);
      end
      isots_pkg::PH_FRAC1: begin
        bump = 1'b0;
        if (dig) begin
          add_fraction_digit(d);
          pos = isots_pkg::PH_FRACN;
        end else begin
          ok = 1'b0;
        end
      end
      isots_pkg::PH_FRACN: begin
        bump = 1'b0;
        if (dig) add_fraction_digit(d);
        else if (c == isots_pkg::CH_Z) pos = isots_pkg::PH_DONE_Z;
        else ok = take_offset_sign(c);
      end
      default: begin
        if (pos <= isots_pkg::PH_YEAR3) begin
          if (dig) year_v = 14'(year_v * 10 + d); else ok = 1'b0;
        end else begin
          // Anything after 'Z' or after the offset minutes is an error.
          bump = 1'b0;
          ok = 1'b0;
        end
      end
    endcase
    if (ok && bump) pos = pos + 5'd1;
    if (!ok) bad_char = 1'b1;
  endfunction

  function bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function int month_length(input int y, input int m);
    int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && leap_year(y)) return 29;
    return lens[m - 1];
  endfunction

  // Days since 1970-01-01 of a civil date, counting years from March so that
  // the leap day falls at the end of the year.
  function longint civil_days(input longint y, input longint m, input longint d);
    longint yy;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    yy = y - ((m <= 2) ? 1 : 0);
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Close the string on its last character: range checks, then conversion.
  function stamp_t close_string();
    stamp_t res;
    int     dim;
    longint frac;
    longint off;
    longint ms;
    res.ok = !bad_char && (pos == isots_pkg::PH_DONE_Z || pos == isots_pkg::PH_DONE_OFF);
    res.ms = '0;
    dim = month_length(int'(year_v), int'(mon_v));
    if (dim == 0 || day_v < 1 || int'(day_v) > dim || hour_v > 23 || min_v > 59 ||
        sec_v > 59 || off_hour_v > 23 || off_min_v > 59)
      res.ok = 1'b0;
    if (res.ok) begin
      frac = longint'(millis_v);
      for (int k = int'(frac_digits); k < 3; k++) frac = frac * 10;
      off = longint'(off_hour_v) * 60 + longint'(off_min_v);
      if (off_neg) off = -off;
      ms = civil_days(longint'(year_v), longint'(mon_v), longint'(day_v));
      ms = ((ms * 24 + longint'(hour_v)) * 60 + longint'(min_v)) * 60 + longint'(sec_v);
      ms = ms * 1000 + frac - off * 60000;
      res.ms = ms[isots_pkg::EPOCH_W-1:0];
    end
    clear_parser();
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones, and now and then a
  // calm stretch with no gaps at all.
  function int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one character word and wait for it to be taken. The prediction
  // is updated only once the word has actually been accepted.
  task automatic send_char(input logic [7:0] c, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    take_char(c);
    if (last) pending_stamps.push_back(close_string());
  endtask

  function void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function void push_num(input int v, input int n);
    int div;
    div = 1;
    for (int i = 1; i < n; i++) div = div * 10;
    for (int i = 0; i < n; i++) begin
      text_buf.push_back(8'(int'(isots_pkg::CH_ZERO) + (v / div) % 10));
      div = div / 10;
    end
  endfunction

  // Send the buffered text; the final character carries the last flag unless
  // the string is meant to run on into the next one.
  task automatic send_text(input bit with_last);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_char(text_buf[i], with_last && (i == n - 1));
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    push_str(s);
    send_text(1'b1);
  endtask

  // Build a well-formed timestamp with random content. Fields mostly stay in
  // range; a share of them go anywhere two digits allow, to hit range checks.
  function void build_timestamp();
    int year;
    int n;
    case ($urandom_range(0, 9))
      0: year = $urandom_range(0, 3);
      1: year = $urandom_range(9996, 9999);
      2: year = 100 * $urandom_range(0, 99);
      3, 4: year = $urandom_range(0, 9999);
      default: year = $urandom_range(1900, 2100);
    endcase
    push_num(year, 4);
    text_buf.push_back(isots_pkg::CH_DASH);
    push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
    text_buf.push_back(isots_pkg::CH_DASH);
    case ($urandom_range(0, 9))
      0: push_num($urandom_range(0, 99), 2);
      1, 2, 3: push_num($urandom_range(28, 31), 2);
      default: push_num($urandom_range(1, 28), 2);
    endcase
    text_buf.push_back(isots_pkg::CH_T);
    push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
    text_buf.push_back(isots_pkg::CH_COLON);
    push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    text_buf.push_back(isots_pkg::CH_COLON);
    push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    if ($urandom_range(0, 9) < 6) begin
      text_buf.push_back(isots_pkg::CH_DOT);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        text_buf.push_back(8'(isots_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) < 4) begin
      text_buf.push_back(isots_pkg::CH_Z);
    end else begin
      text_buf.push_back($urandom_range(0, 1) ? isots_pkg::CH_DASH : isots_pkg::CH_PLUS);
      push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
      text_buf.push_back(isots_pkg::CH_COLON);
      push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random back pressure, mostly ready with short stalls and
  // a few long ones.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : ready_gen
    int r;
    int hold;
    if (hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
        hold = $urandom_range(1, 40);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        hold = $urandom_range(1, 4);
      end else begin
        out_tready <= 1'b0;
        hold = $urandom_range(20, 60);
      end
    end else begin
      hold = hold - 1;
    end
  end

  // Each accepted result word is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    stamp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stamps.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: valid=%0b ms=%0d",
                                  out_tuser, $signed(out_tdata[isots_pkg::EPOCH_W-1:0])));
      end else begin
        want = pending_stamps.pop_front();
        if (out_tuser !== want.ok)
          report_mismatch($sformatf("valid_res got %0b expected %0b", out_tuser, want.ok));
        if (out_tdata[isots_pkg::EPOCH_W-1:0] !== want.ms)
          report_mismatch($sformatf("epoch_ms got %0d expected %0d",
                                    $signed(out_tdata[isots_pkg::EPOCH_W-1:0]),
                                    $signed(want.ms)));
        if (out_tdata[isots_pkg::TDATA_OUT_W-1:isots_pkg::EPOCH_W] !== '0)
          report_mismatch($sformatf("tdata pad bits not zero: %h",
                                    out_tdata[isots_pkg::TDATA_OUT_W-1:isots_pkg::EPOCH_W]));
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // The epoch itself, and the outer ends of the range with extreme offsets.
  task automatic test_extremes();
    send_str("1970-01-01T00:00:00Z");
    send_str("0000-01-01T00:00:00+23:59");
    send_str("0000-02-29T23:59:59-00:00");
    send_str("9999-12-31T23:59:59.999-23:59");
    send_str("1969-12-31T23:59:59.999Z");
  endtask

  // One, two and more than three fraction digits; a dot with no digit after it.
  task automatic test_fractions();
    send_str("2000-02-29T12:34:56.7Z");
    send_str("2024-02-29T01:02:03.45+05:30");
    send_str("2024-07-15T08:00:00.123456789-08:00");
    send_str("2024-07-15T08:00:00.Z");
  endtask

  // Range checks on the last character, including the Gregorian leap rule.
  task automatic test_calendar_limits();
    send_str("1900-02-29T00:00:00Z");
    send_str("2023-02-29T00:00:00Z");
    send_str("2023-13-01T00:00:00Z");
    send_str("2023-00-10T00:00:00Z");
    send_str("2023-04-31T00:00:00Z");
    send_str("2023-01-00T00:00:00Z");
    send_str("2023-01-01T24:00:00Z");
    send_str("2023-01-01T00:60:00Z");
    send_str("2023-01-01T00:00:60Z");
    send_str("2023-01-01T00:00:00+24:00");
    send_str("2023-01-01T00:00:00-00:60");
  endtask

  // Wrong characters, short strings, trailing characters and non-ASCII bytes.
  task automatic test_malformed();
    send_str("2023-01-01T00:00:00");
    send_str("Z");
    send_str("2023/01-01T00:00:00Z");
    send_str("2023-01-01t00:00:00Z");
    send_str("2023-01-01T00:00:00ZZ");
    send_str("2023-01-01T00:00:00+05:30X");
    send_str("2023-01-01T00:00:00+05:3");
    push_str("2023-01-01T00:00:00Z");
    text_buf[2] = 8'hFF;
    send_text(1'b1);
    push_str("2023-01-01T00:00:00Z");
    text_buf[18] = 8'h00;
    send_text(1'b1);
  endtask

  // Mostly well-formed strings with random content; the rest corrupted, cut short
  // or extended strings, strings that run on without a last flag, and pure noise.
  task automatic test_random_stream();
    int start;
    int mode;
    int keep;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        build_timestamp();
        send_text(1'b1);
      end else if (mode < 80) begin
        build_timestamp();
        text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        send_text(1'b1);
      end else if (mode < 86) begin
        build_timestamp();
        keep = $urandom_range(1, text_buf.size() - 1);
        while (text_buf.size() > keep) void'(text_buf.pop_back());
        send_text(1'b1);
      end else if (mode < 90) begin
        build_timestamp();
        case ($urandom_range(0, 2))
          0: text_buf.push_back(isots_pkg::CH_Z);
          1: text_buf.push_back(8'(isots_pkg::CH_ZERO + $urandom_range(0, 9)));
          default: text_buf.push_back(8'($urandom_range(0, 255)));
        endcase
        send_text(1'b1);
      end else if (mode < 93) begin
        // No last flag: the next string is appended to this one.
        build_timestamp();
        send_text(1'b0);
      end else begin
        keep = $urandom_range(1, 30);
        for (int i = 0; i < keep; i++) text_buf.push_back(8'($urandom_range(0, 255)));
        send_text(1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_fractions();
    test_calendar_limits();
    test_malformed();
    test_random_stream();

    // Drain: wait for every pending result, then keep watching for a stray word
    // that may follow. The watchdog bounds this wait.
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/isots_pkg.sv
rtl/isots_front.sv
rtl/isots_queue.sv
rtl/isots_back.sv
rtl/iso_timestamp_to_epoch_ms.sv
rtl/isots_checker.sv
sim/testbench.sv
